### design/bglis_pkg.sv
`default_nettype none
package bglis_pkg;

	localparam int VALUE_BITS_DEF = 12;
	localparam int LEN_BITS_DEF   = 16;
	localparam int GAP_BITS       = 12;
	// sequence tag kept with every tree node; a wrap forces a full sweep
	localparam int EPOCH_BITS     = 4;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_QINIT,
		ST_QUERY,
		ST_QDONE,
		ST_UPD0,
		ST_UPD,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

### design/bglis_ram.sv
`default_nettype none
module bglis_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
`default_nettype wire

### design/bounded_gap_lis_max_tree.sv
// Each item runs a range query, then a leaf-to-root update, before its result is
// valid. A new item is taken only after the last one is done, as the single tree
// memory is walked up from the leaves for the query and for the update; a held
// result stalls it.
// Reset: max_gap = 1, best = 1, then all 2^(VALUE_BITS+1) tree nodes are swept
// (in_ready low); the sweep reruns, delaying that item, on every 16th first flag.
`default_nettype none
module bounded_gap_lis_max_tree #(
	parameter int VALUE_BITS = bglis_pkg::VALUE_BITS_DEF,
	parameter int LEN_BITS   = bglis_pkg::LEN_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [bglis_pkg::GAP_BITS-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire logic                  first,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [LEN_BITS-1:0]        item_length,
	output logic [LEN_BITS-1:0]        best_length
);

	import bglis_pkg::*;

	localparam int NB  = VALUE_BITS + 1;
	localparam int LRW = NB + 1;
	localparam int GW  = (VALUE_BITS > GAP_BITS) ? VALUE_BITS : GAP_BITS;
	localparam int MW  = EPOCH_BITS + LEN_BITS;
	localparam logic [LRW-1:0] LEAF = LRW'(1) << VALUE_BITS;
	localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

	state_t state_q, state_d;

	logic [GAP_BITS-1:0]   gap_q;
	logic [LEN_BITS-1:0]   best_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic [NB-1:0]         clr_q;
	logic                  pend_q;
	logic [VALUE_BITS-1:0] x_q;
	logic [LRW-1:0]        l_q, r_q;
	logic                  va_s1, vb_s1;
	logic [LEN_BITS-1:0]   m_q, len_q, cur_q;
	logic [NB-1:0]         n_q;
	logic                  out_valid_q;
	logic [LEN_BITS-1:0]   item_length_q, best_length_q;

	logic          we;
	logic [NB-1:0] waddr, ra_a, ra_b;
	logic [MW-1:0] wdata, rd_a, rd_b;

	bglis_ram #(
		.WIDTH (MW),
		.DEPTH (1 << NB)
	) u_tree (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (ra_a),
		.rdata_a (rd_a),
		.raddr_b (ra_b),
		.rdata_b (rd_b)
	);

	// a node tagged with an older sequence reads as zero
	function automatic logic [LEN_BITS-1:0] node_len(input logic [MW-1:0] d,
		input logic [EPOCH_BITS-1:0] ep);
		return (d[MW-1:LEN_BITS] == ep) ? d[LEN_BITS-1:0] : '0;
	endfunction

	logic [GW-1:0]         xg, gg;
	logic [VALUE_BITS-1:0] lo;
	logic                  q_empty;
	logic [LRW-1:0]        rm1;
	logic [LEN_BITS-1:0]   a_len, b_len, ab_max, m_next, len_c, sib_len, wmax;
	logic [NB-1:0]         nn;
	logic                  clr_done, out_load, epoch_wrap;

	assign xg       = GW'(x_q);
	assign gg       = GW'(gap_q);
	assign lo       = (xg > gg) ? VALUE_BITS'(xg - gg) : '0;
	assign q_empty  = (x_q == '0) || (gap_q == '0);
	assign rm1      = r_q - LRW'(1);
	assign a_len    = va_s1 ? node_len(rd_a, epoch_q) : '0;
	assign b_len    = vb_s1 ? node_len(rd_b, epoch_q) : '0;
	assign ab_max   = (a_len > b_len) ? a_len : b_len;
	assign m_next   = (ab_max > m_q) ? ab_max : m_q;
	assign len_c    = (m_q == LEN_MAX) ? LEN_MAX : m_q + LEN_BITS'(1);
	assign sib_len  = node_len(rd_a, epoch_q);
	assign wmax     = (sib_len > cur_q) ? sib_len : cur_q;
	assign nn       = n_q >> 1;
	assign clr_done = (clr_q == '1);
	assign out_load = !out_valid_q || out_ready;
	assign epoch_wrap = (epoch_q == '1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_done) state_d = pend_q ? ST_QINIT : ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = (first && epoch_wrap) ? ST_CLEAR : ST_QINIT;
			end
			ST_QINIT: state_d = ST_QUERY;
			ST_QUERY: begin
				if (!(l_q < r_q)) state_d = ST_QDONE;
			end
			ST_QDONE: state_d = ST_UPD0;
			ST_UPD0:  state_d = ST_UPD;
			ST_UPD: begin
				if (nn == NB'(1)) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		we       = 1'b0;
		waddr    = '0;
		wdata    = '0;
		ra_a     = '0;
		ra_b     = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = {epoch_q, {LEN_BITS{1'b0}}};
			end
			ST_IDLE: in_ready = 1'b1;
			ST_QUERY: begin
				ra_a = l_q[NB-1:0];
				ra_b = rm1[NB-1:0];
			end
			ST_UPD0: begin
				we    = 1'b1;
				waddr = n_q;
				wdata = {epoch_q, len_q};
				ra_a  = n_q ^ NB'(1);
			end
			ST_UPD: begin
				we    = 1'b1;
				waddr = nn;
				wdata = {epoch_q, wmax};
				ra_a  = nn ^ NB'(1);
			end
			default: ;
		endcase
	end

	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign item_length = item_length_q;
	assign best_length = best_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			gap_q       <= GAP_BITS'(1);
			best_q      <= LEN_BITS'(1);
			epoch_q     <= '0;
			clr_q       <= '0;
			pend_q      <= 1'b0;
			va_s1       <= 1'b0;
			vb_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) gap_q <= cfg_data;
			if (state_q == ST_DONE && out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + NB'(1);
				ST_IDLE: begin
					if (in_valid) begin
						x_q    <= value;
						pend_q <= 1'b1;
						if (first) begin
							epoch_q <= epoch_q + EPOCH_BITS'(1);
							best_q  <= LEN_BITS'(1);
						end
					end
				end
				ST_QINIT: begin
					l_q   <= q_empty ? '0 : LRW'(lo) + LEAF;
					r_q   <= q_empty ? '0 : LRW'(x_q) + LEAF;
					m_q   <= '0;
					va_s1 <= 1'b0;
					vb_s1 <= 1'b0;
				end
				ST_QUERY: begin
					m_q <= m_next;
					if (l_q < r_q) begin
						va_s1 <= l_q[0];
						vb_s1 <= r_q[0];
						l_q   <= (l_q + LRW'(l_q[0])) >> 1;
						r_q   <= (r_q - LRW'(r_q[0])) >> 1;
					end else begin
						va_s1 <= 1'b0;
						vb_s1 <= 1'b0;
					end
				end
				ST_QDONE: begin
					len_q <= len_c;
					if (len_c > best_q) best_q <= len_c;
					n_q <= {1'b1, x_q};
				end
				ST_UPD0: cur_q <= len_q;
				ST_UPD: begin
					cur_q <= wmax;
					n_q   <= nn;
				end
				ST_DONE: begin
					if (out_load) begin
						item_length_q <= len_q;
						best_length_q <= best_q;
						pend_q        <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside completion");

	a_query_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QUERY) |-> (l_q <= r_q))
		else $error("query bounds crossed");

	a_upd_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> (n_q >= NB'(2)))
		else $error("update walked past root");

	a_upd_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD0 || state_q == ST_UPD) |-> (waddr != ra_a))
		else $error("sibling read hits node being written");

	a_best_ge_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (best_length_q >= item_length_q))
		else $error("best below item length");

endmodule
`default_nettype wire
